// ----- design/salc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// salc_pkg: shared types for the set-associative cache
// Holds the sequencer state enumeration, register indexes and line metadata record.
// ---------------------------------------------------------------------------
package salc_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_LOOKCHK,
    ST_VICT,
    ST_VICTCHK,
    ST_WBCHK,
    ST_WBRD,
    ST_WBWR,
    ST_FILLRD,
    ST_FILLWR,
    ST_ACCESS,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_INDEX_BITS  = 3'd0;
  localparam logic [2:0] REG_OFFSET_BITS = 3'd1;
  localparam logic [2:0] REG_WAYS        = 3'd2;
  localparam logic [2:0] REG_WALLOC      = 3'd3;
  localparam logic [2:0] REG_WBACK       = 3'd4;

  localparam int TAG_W   = 12;
  localparam int STAMP_W = 32;
  localparam int WORD_W  = 32;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } meta_t;

endpackage
`default_nettype wire

// ----- design/set_assoc_lru_cache.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// set_assoc_lru_cache: set-associative LRU cache with internal backing memory
// Write-back/write-through, optional write-allocate, one access at a time.
// ---------------------------------------------------------------------------
// One access is taken at a time; s_tready is low while it is worked on. The
// finished result waits in the output register, so the next access can be
// taken while it is held; only the end of that next access waits for it.
// After reset a clearing pass zeroes the backing memory (line metadata is
// cleared in the same pass) before the first transfer is taken. Each access
// is sequenced through the single metadata port and the single backing
// memory port.
module set_assoc_lru_cache #(
  parameter int MAX_SETS       = 64,
  parameter int MAX_WAYS       = 8,
  parameter int MAX_LINE_WORDS = 16,
  parameter int MEM_WORDS      = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // address[13:0], write_data[45:14], zeros
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // read_data, hit, wrote_back, memory_written
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LW_W   = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
  localparam int NLINES = MAX_SETS * MAX_WAYS;
  localparam int LN_W   = $clog2(NLINES) > 0 ? $clog2(NLINES) : 1;
  localparam int MEM_W  = $clog2(MEM_WORDS);
  localparam int CLR_N  = (MEM_WORDS > NLINES) ? MEM_WORDS : NLINES;
  localparam int CLR_W  = $clog2(CLR_N) + 1;
  localparam int DA_W   = LN_W + LW_W;
  localparam int MAXIB  = $clog2(MAX_SETS);
  localparam int MAXOB  = $clog2(MAX_LINE_WORDS) + 2;

  // configuration registers
  logic [2:0] index_bits, offset_bits;
  logic [3:0] ways_in_use;
  logic       write_allocate, write_back;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits     <= 3'd2;
      offset_bits    <= 3'd4;
      ways_in_use    <= 4'd2;
      write_allocate <= 1'b1;
      write_back     <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        salc_pkg::REG_INDEX_BITS:  index_bits     <= pwdata[2:0];
        salc_pkg::REG_OFFSET_BITS: offset_bits    <= pwdata[2:0];
        salc_pkg::REG_WAYS:        ways_in_use    <= pwdata[3:0];
        salc_pkg::REG_WALLOC:      write_allocate <= pwdata[0];
        salc_pkg::REG_WBACK:       write_back     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      salc_pkg::REG_INDEX_BITS:  prdata[2:0] = index_bits;
      salc_pkg::REG_OFFSET_BITS: prdata[2:0] = offset_bits;
      salc_pkg::REG_WAYS:        prdata[3:0] = ways_in_use;
      salc_pkg::REG_WALLOC:      prdata[0]   = write_allocate;
      salc_pkg::REG_WBACK:       prdata[0]   = write_back;
      default: ;
    endcase
  end

  // effective geometry, clamped to the build limits
  logic [2:0] ib_eff, ob_eff;
  logic [3:0] ways_eff;
  always_comb begin
    ib_eff = (32'(index_bits) > MAXIB) ? 3'(MAXIB) : index_bits;
    ob_eff = (offset_bits < 3'd2) ? 3'd2 : offset_bits;
    if (32'(ob_eff) > MAXOB) ob_eff = 3'(MAXOB);
    ways_eff = (ways_in_use == 4'd0) ? 4'd1 : ways_in_use;
    if (32'(ways_eff) > MAX_WAYS) ways_eff = 4'(MAX_WAYS);
  end

  // memories
  salc_pkg::meta_t              meta_mem [NLINES];
  logic [salc_pkg::WORD_W-1:0]  data_mem [NLINES*MAX_LINE_WORDS];
  logic [salc_pkg::WORD_W-1:0]  bmem     [MEM_WORDS];

  // request and working registers
  salc_pkg::state_t state, state_next;
  logic              kind;
  logic [13:0]       addr;
  logic [31:0]       wdata;
  logic [SET_W-1:0]  set_q;
  logic [11:0]       tag_q;
  logic [LW_W-1:0]   woff;
  logic [6:0]        lwords;
  logic [4:0]        way;
  logic [WAY_W-1:0]  victim;
  logic [31:0]       vstamp;
  logic [6:0]        kcnt;
  logic [31:0]       use_clock;
  logic              hit, wb, memw, found;
  logic [CLR_W-1:0]  clr;
  salc_pkg::meta_t   meta_rd;
  logic [31:0]       data_rd, mem_rd;
  logic [11:0]       vtag;
  logic [3:0]        wayv_probe;

  logic [LN_W-1:0]   line_sel;
  logic [31:0]       vword, fword;
  logic [MEM_W-1:0]  mem_addr;
  logic [DA_W-1:0]   data_addr;

  logic [31:0] set_full;
  assign set_full   = 32'(set_q);
  assign wayv_probe = way[3:0];
  assign line_sel   = LN_W'(set_full * MAX_WAYS + 32'(way[WAY_W-1:0]));

  always_comb begin
    vword = (((32'(vtag) << ib_eff) | set_full) << ob_eff) >> 2;
    fword = ((32'(addr) >> ob_eff) << ob_eff) >> 2;
  end

  logic [LN_W-1:0] vline;
  assign vline = LN_W'(set_full * MAX_WAYS + 32'(victim));

  // backing memory address per state
  always_comb begin
    unique case (state)
      salc_pkg::ST_WBRD, salc_pkg::ST_WBWR:
        mem_addr = MEM_W'(vword + 32'(kcnt));
      salc_pkg::ST_FILLRD, salc_pkg::ST_FILLWR:
        mem_addr = MEM_W'(fword + 32'(kcnt));
      default:
        mem_addr = MEM_W'(32'(addr) >> 2);
    endcase
  end

  always_comb begin
    unique case (state)
      salc_pkg::ST_WBRD, salc_pkg::ST_WBWR, salc_pkg::ST_FILLRD, salc_pkg::ST_FILLWR:
        data_addr = DA_W'(32'(vline) * MAX_LINE_WORDS + 32'(kcnt));
      default:
        data_addr = DA_W'(32'(vline) * MAX_LINE_WORDS + 32'(woff));
    endcase
  end

  assign s_tready = (state == salc_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      salc_pkg::ST_CLEAR:
        if (32'(clr) == CLR_N - 1) state_next = salc_pkg::ST_IDLE;
      salc_pkg::ST_IDLE:
        if (s_tvalid && s_tready) state_next = salc_pkg::ST_LOOK;
      salc_pkg::ST_LOOK: state_next = salc_pkg::ST_LOOKCHK;
      salc_pkg::ST_LOOKCHK:
        if (meta_rd.valid && meta_rd.tag == tag_q) state_next = salc_pkg::ST_ACCESS;
        else if (wayv_probe + 4'd1 < ways_eff) state_next = salc_pkg::ST_LOOK;
        else if (kind && !write_allocate) state_next = salc_pkg::ST_ACCESS;
        else state_next = salc_pkg::ST_VICT;
      salc_pkg::ST_VICT: state_next = salc_pkg::ST_VICTCHK;
      salc_pkg::ST_VICTCHK:
        if (!meta_rd.valid) state_next = salc_pkg::ST_FILLRD;
        else if (wayv_probe + 4'd1 < ways_eff) state_next = salc_pkg::ST_VICT;
        else state_next = salc_pkg::ST_WBCHK; // victim metadata read next
      salc_pkg::ST_WBCHK: state_next = salc_pkg::ST_WBRD;
      salc_pkg::ST_WBRD:
        if (kcnt == 7'd0 && !meta_rd.dirty) state_next = salc_pkg::ST_FILLRD;
        else state_next = salc_pkg::ST_WBWR;
      salc_pkg::ST_WBWR:
        if (kcnt + 7'd1 == lwords) state_next = salc_pkg::ST_FILLRD;
        else state_next = salc_pkg::ST_WBRD;
      salc_pkg::ST_FILLRD: state_next = salc_pkg::ST_FILLWR;
      salc_pkg::ST_FILLWR:
        if (kcnt + 7'd1 == lwords) state_next = salc_pkg::ST_ACCESS;
        else state_next = salc_pkg::ST_FILLRD;
      salc_pkg::ST_ACCESS:
        state_next = salc_pkg::ST_RDWAIT;
      salc_pkg::ST_RDWAIT: state_next = salc_pkg::ST_DONE;
      salc_pkg::ST_DONE:
        if (!m_tvalid || m_tready) state_next = salc_pkg::ST_IDLE;
      default: state_next = salc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= salc_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // memory ports: one read and one write per memory per cycle
  always_ff @(posedge clk) begin
    meta_rd <= meta_mem[(state == salc_pkg::ST_WBCHK || state == salc_pkg::ST_WBRD
                         || state == salc_pkg::ST_VICTCHK) ? vline : line_sel];
    data_rd <= data_mem[data_addr];
    mem_rd  <= bmem[mem_addr];
  end

  // backing memory write
  always_ff @(posedge clk) begin
    if (state == salc_pkg::ST_CLEAR) begin
      if (32'(clr) < MEM_WORDS) bmem[MEM_W'(clr)] <= '0;
    end else if (state == salc_pkg::ST_WBWR) begin
      bmem[mem_addr] <= data_rd;
    end else if (state == salc_pkg::ST_ACCESS && kind && (!found ? !write_allocate
                 : !write_back) && !(found == 1'b0 && write_allocate && !write_back
                 && 1'b0)) begin
      bmem[mem_addr] <= wdata;
    end else if (state == salc_pkg::ST_RDWAIT && kind && !found && write_allocate
                 && !write_back && memw) begin
      bmem[mem_addr] <= wdata;
    end
  end

  // metadata write
  always_ff @(posedge clk) begin
    if (state == salc_pkg::ST_CLEAR) begin
      if (32'(clr) < NLINES) meta_mem[LN_W'(clr)] <= '0;
    end else if (state == salc_pkg::ST_FILLWR && kcnt + 7'd1 == lwords) begin
      meta_mem[vline] <= '{valid: 1'b1, dirty: 1'b0, tag: tag_q, stamp: 32'd0};
    end else if (state == salc_pkg::ST_RDWAIT && !(kind && !found && !write_allocate)) begin
      meta_mem[vline] <= '{valid: 1'b1, dirty: (kind && write_back) ? 1'b1
                           : (found ? meta_rd.dirty : 1'b0),
                           tag: tag_q, stamp: use_clock};
    end
  end

  // line data write
  always_ff @(posedge clk) begin
    if (state == salc_pkg::ST_FILLWR) begin
      data_mem[data_addr] <= mem_rd;
    end else if (state == salc_pkg::ST_ACCESS && kind && !(!found && !write_allocate)) begin
      data_mem[data_addr] <= wdata;
    end
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      use_clock <= '0;
      m_tvalid  <= 1'b0;
      way       <= '0;
      kcnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && state != salc_pkg::ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        salc_pkg::ST_CLEAR: clr <= clr + CLR_W'(1);
        salc_pkg::ST_IDLE:
          if (s_tvalid && s_tready) begin
            kind   <= s_tuser;
            addr   <= s_tdata[13:0];
            wdata  <= s_tdata[45:14];
            set_q  <= SET_W'((32'(s_tdata[13:0]) >> ob_eff) & ((32'd1 << ib_eff) - 32'd1));
            tag_q  <= 12'((32'(s_tdata[13:0]) >> (4'(ob_eff) + 4'(ib_eff))));
            woff   <= LW_W'((32'(s_tdata[13:0]) >> 2) & ((32'd1 << (ob_eff - 3'd2)) - 32'd1));
            lwords <= 7'(32'd1 << (ob_eff - 3'd2));
            way    <= '0;
            victim <= '0;
            found  <= 1'b0;
            hit    <= 1'b0;
            wb     <= 1'b0;
            memw   <= 1'b0;
            kcnt   <= '0;
          end
        salc_pkg::ST_LOOK: use_clock <= use_clock + 32'd1;
        salc_pkg::ST_LOOKCHK:
          if (meta_rd.valid && meta_rd.tag == tag_q) begin
            found  <= 1'b1;
            hit    <= 1'b1;
            victim <= WAY_W'(way);
          end else if (wayv_probe + 4'd1 < ways_eff) begin
            way <= way + 5'd1;
          end else begin
            way <= '0;
            if (kind && !write_allocate) memw <= 1'b1;
          end
        salc_pkg::ST_VICT: use_clock <= use_clock + 32'd1;
        salc_pkg::ST_VICTCHK:
          if (!meta_rd.valid) begin
            victim <= WAY_W'(way);
          end else begin
            if (way == 5'd0 || meta_rd.stamp < vstamp) begin
              victim <= WAY_W'(way);
              vstamp <= meta_rd.stamp;
            end
            if (wayv_probe + 4'd1 < ways_eff) way <= way + 5'd1;
          end
        salc_pkg::ST_WBRD: begin
          // metadata of the chosen victim is valid on the first pass
          if (kcnt == 7'd0) begin
            wb   <= meta_rd.dirty;
            vtag <= meta_rd.tag;
          end
        end
        salc_pkg::ST_WBWR:
          kcnt <= (kcnt + 7'd1 == lwords) ? 7'd0 : kcnt + 7'd1;
        salc_pkg::ST_FILLWR:
          kcnt <= kcnt + 7'd1;
        salc_pkg::ST_ACCESS:
          if (kind && !(!found && !write_allocate) && !write_back) memw <= 1'b1;
        salc_pkg::ST_RDWAIT: ;
        salc_pkg::ST_DONE:
          // result register frees once the previous transfer has gone
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, memw, wb, hit,
                         (kind || (!found && kind)) ? 32'd0 : data_rd};
          end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_set_assoc_lru_cache.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_set_assoc_lru_cache: self-checking bench for the set-associative cache
// Drives read and write accesses over the stream port and predicts each
// result with a behavioural copy of the cache, its LRU stamps and the
// backing memory. It reconfigures the geometry and write policy between
// phases over the register port, the extremes included.
// ---------------------------------------------------------------------------
module tb_set_assoc_lru_cache;

  localparam int NSETS     = 64;
  localparam int NWAYS     = 8;
  localparam int LWORDS    = 16;
  localparam int MWORDS    = 4096;
  localparam int CYC_LIMIT = 1000000;
  localparam int NPHASES   = 10;

  typedef struct {
    bit          is_wr;
    logic [13:0] addr;
    logic [31:0] wdata;
  } access_t;

  typedef struct {
    logic [31:0] read_data;
    bit          hit;
    bit          wrote_back;
    bit          memory_written;
  } outcome_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;   // address[13:0], write_data[45:14], zeros
  logic        s_tuser;   // kind
  logic        m_tvalid, m_tready;
  logic [39:0] m_tdata;   // read_data[31:0], hit, wrote_back, memory_written
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  set_assoc_lru_cache DUT (.*);

  // cache image kept by the bench
  logic [2:0]  cfg_index, cfg_offset;
  logic [3:0]  cfg_ways;
  bit          cfg_walloc, cfg_wback;
  logic [11:0] tags  [NSETS*NWAYS];
  bit          valid [NSETS*NWAYS];
  bit          dirty [NSETS*NWAYS];
  logic [31:0] stamp [NSETS*NWAYS];
  logic [31:0] ldata [NSETS*NWAYS*LWORDS];
  bit          known [NSETS*NWAYS*LWORDS];
  logic [31:0] mem   [MWORDS];
  logic [31:0] use_clock;

  access_t  pending_q[$];
  outcome_t outcome_q[$];
  int       cycles = 0;
  bit       failed;

  // geometry after clamping, and address split
  function automatic void split(input logic [13:0] a, output int ib, output int ob,
                                output int ways, output int lw, output int set_i,
                                output int tag, output int woff);
    ib = cfg_index;
    while (ib > 0 && (1 << ib) > NSETS) ib--;
    ob = (cfg_offset < 2) ? 2 : cfg_offset;
    while (ob > 2 && (1 << (ob - 2)) > LWORDS) ob--;
    ways = (cfg_ways < 1) ? 1 : (cfg_ways > NWAYS) ? NWAYS : cfg_ways;
    lw    = 1 << (ob - 2);
    set_i = (a >> ob) & ((1 << ib) - 1);
    tag   = (a >> (ob + ib)) & 12'hFFF;
    woff  = (a >> 2) & (lw - 1);
  endfunction

  // a read hit on a word never filled would be undefined in the block
  function automatic bit reads_unknown(input logic [13:0] a);
    int ib, ob, ways, lw, set_i, tag, woff;
    split(a, ib, ob, ways, lw, set_i, tag, woff);
    for (int w = 0; w < ways; w++)
      if (valid[set_i*NWAYS+w] && tags[set_i*NWAYS+w] == tag)
        return !known[(set_i*NWAYS+w)*LWORDS+woff];
    return 0;
  endfunction

  function automatic outcome_t cache_access(input access_t acc);
    int ib, ob, ways, lw, set_i, tag, woff, base, line, victim, vword, fword;
    bit found, got_inv;
    outcome_t r;
    r = '{default: 0};
    split(acc.addr, ib, ob, ways, lw, set_i, tag, woff);
    base  = set_i * NWAYS;
    found = 0;
    line  = 0;
    for (int w = 0; w < ways; w++) begin
      use_clock++;
      if (valid[base+w] && tags[base+w] == tag) begin
        found = 1;
        line  = base + w;
        break;
      end
    end
    r.hit = found;
    if (!found && acc.is_wr && !cfg_walloc) begin
      mem[(acc.addr >> 2) % MWORDS] = acc.wdata;
      r.memory_written = 1;
      return r;
    end
    if (!found) begin
      victim  = base;
      got_inv = 0;
      for (int w = 0; w < ways; w++) begin
        use_clock++;
        if (!valid[base+w]) begin
          victim  = base + w;
          got_inv = 1;
          break;
        end
        if (stamp[base+w] < stamp[victim]) victim = base + w;
      end
      // dirty victim goes back at the address rebuilt from current geometry
      if (!got_inv && dirty[victim]) begin
        vword = (((int'(tags[victim]) << ib) | (victim / NWAYS)) << ob) >> 2;
        for (int k = 0; k < lw; k++) mem[(vword + k) % MWORDS] = ldata[victim*LWORDS+k];
        r.wrote_back = 1;
      end
      fword = ((acc.addr >> ob) << ob) >> 2;
      for (int k = 0; k < lw; k++) begin
        ldata[victim*LWORDS+k] = mem[(fword + k) % MWORDS];
        known[victim*LWORDS+k] = 1;
      end
      tags[victim]  = tag;
      valid[victim] = 1;
      dirty[victim] = 0;
      line = victim;
    end
    stamp[line] = use_clock;
    if (acc.is_wr) begin
      ldata[line*LWORDS+woff] = acc.wdata;
      known[line*LWORDS+woff] = 1;
      if (cfg_wback) dirty[line] = 1;
      else begin
        mem[(acc.addr >> 2) % MWORDS] = acc.wdata;
        r.memory_written = 1;
      end
    end else
      r.read_data = ldata[line*LWORDS+woff];
    return r;
  endfunction

  task automatic add_access(input bit is_wr, input logic [13:0] a, input logic [31:0] d);
    access_t acc;
    acc = '{is_wr: is_wr, addr: a, wdata: d};
    if (!is_wr && reads_unknown(a)) acc.is_wr = 1;
    outcome_q.push_back(cache_access(acc));
    pending_q.push_back(acc);
  endtask

  // register write: setup phase, then access phase
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      salc_pkg::REG_INDEX_BITS:  cfg_index  = v[2:0];
      salc_pkg::REG_OFFSET_BITS: cfg_offset = v[2:0];
      salc_pkg::REG_WAYS:        cfg_ways   = v[3:0];
      salc_pkg::REG_WALLOC:      cfg_walloc = v[0];
      salc_pkg::REG_WBACK:       cfg_wback  = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ib, input int ob, input int wy, input int wa, input int wb);
    reg_write(salc_pkg::REG_INDEX_BITS, ib);
    reg_write(salc_pkg::REG_OFFSET_BITS, ob);
    reg_write(salc_pkg::REG_WAYS, wy);
    reg_write(salc_pkg::REG_WALLOC, wa);
    reg_write(salc_pkg::REG_WBACK, wb);
  endtask

  task automatic drain;
    wait (pending_q.size() == 0 && outcome_q.size() == 0);
    @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // idling off in a long calm window
  function automatic bit take_gap();
    if (cycles >= 8000 && cycles < 20000) return 0;
    return $urandom_range(0, 99) < 15;
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tuser  <= 0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_q.size() != 0 && !take_gap()) begin
        access_t acc;
        acc = pending_q.pop_front();
        s_tvalid <= 1;
        s_tuser  <= acc.is_wr;
        s_tdata  <= {2'b00, acc.wdata, acc.addr};
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no access outstanding");
          failed = 1;
        end else begin
          outcome_t e;
          e = outcome_q.pop_front();
          if (m_tdata[31:0] !== e.read_data) begin
            $error("read_data: expected %h, got %h", e.read_data, m_tdata[31:0]);
            failed = 1;
          end
          if (m_tdata[32] !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, m_tdata[32]);
            failed = 1;
          end
          if (m_tdata[33] !== e.wrote_back) begin
            $error("wrote_back: expected %0d, got %0d", e.wrote_back, m_tdata[33]);
            failed = 1;
          end
          if (m_tdata[34] !== e.memory_written) begin
            $error("memory_written: expected %0d, got %0d", e.memory_written, m_tdata[34]);
            failed = 1;
          end
        end
      end
      m_tready <= !take_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [13:0] pool[24];
    int ib, ob, wy;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cfg_index = 2; cfg_offset = 4; cfg_ways = 2; cfg_walloc = 1; cfg_wback = 1;
    use_clock = 0;
    foreach (tags[i]) begin
      tags[i] = 0; valid[i] = 0; dirty[i] = 0; stamp[i] = 0;
    end
    foreach (ldata[i]) begin
      ldata[i] = 0; known[i] = 0;
    end
    foreach (mem[i]) mem[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    // memory clearing pass
    @(posedge clk);
    wait (s_tready === 1'b1);

    // reset geometry: 4 sets, 16-byte lines, 2 ways, write-back allocate
    add_access(0, 14'h0000, 32'h0);
    add_access(1, 14'h0004, 32'hFFFFFFFF);
    add_access(0, 14'h0007, 32'hFFFFFFFF);
    add_access(0, 14'h3FFF, 32'h0);
    add_access(1, 14'h3FFC, 32'h0);
    add_access(1, 14'h0040, 32'hA5A5A5A5);
    add_access(1, 14'h0080, 32'h5A5A5A5A);   // evicts dirty LRU line
    add_access(0, 14'h0004, 32'h0);          // refetch written-back word
    add_access(0, 14'h0040, 32'h0);
    drain();

    // no allocate, write-through, direct mapped, smallest lines
    set_config(0, 0, 0, 0, 0);
    add_access(1, 14'h1234, 32'h12345678);   // write miss straight to memory
    add_access(0, 14'h1234, 32'h0);
    add_access(1, 14'h1234, 32'hDEADBEEF);   // write hit through to memory
    add_access(0, 14'h2234, 32'h0);
    add_access(0, 14'h1234, 32'h0);
    drain();

    // oversized fields clamp; widest lines and all ways
    set_config(7, 7, 15, 1, 1);
    add_access(1, 14'h0100, 32'h0BADF00D);
    add_access(0, 14'h0100, 32'h0);
    for (int k = 0; k < 9; k++) add_access(1, 14'(k * 4096 + 256), 32'(k));
    drain();

    // random phases, reaching extremes first
    for (int ph = 0; ph < NPHASES; ph++) begin
      case (ph)
        0: set_config(6, 6, 8, 1, 1);
        1: set_config(0, 2, 1, 1, 0);
        2: set_config(6, 2, 8, 0, 1);
        3: set_config(1, 5, 4, 1, 1);   // stale lines from wider geometry
        default: begin
          ib = $urandom_range(0, 7);
          ob = $urandom_range(0, 7);
          wy = $urandom_range(0, 15);
          set_config(ib, ob, wy, $urandom_range(0, 1), $urandom_range(0, 1));
        end
      endcase
      foreach (pool[i]) pool[i] = 14'($urandom_range(0, 16383));
      for (int n = 0; n < 90; n++) begin
        logic [13:0] a;
        logic [31:0] d;
        if ($urandom_range(0, 99) < 80)
          a = (pool[$urandom_range(0, 23)] & 14'h3FC0) | 14'($urandom_range(0, 63));
        else
          a = 14'($urandom_range(0, 16383));
        case ($urandom_range(0, 9))
          0: d = 32'h0;
          1: d = 32'hFFFFFFFF;
          default: d = $urandom;
        endcase
        add_access(1'($urandom_range(0, 1)), a, d);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/salc_pkg.sv
design/set_assoc_lru_cache.sv
bench/tb_set_assoc_lru_cache.sv
